// ===== design/bhdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bump heap descriptor table package
// Shared types and constants for the bump heap bookkeeping block.
// ----------------------------------------------------------------------------
package bhdt_pkg;

   localparam int ADDR_W = 12;
   localparam int SIZE_W = 13;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_REALLOC = 2'd2,
      FUNC_QUERY   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_TAIL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } request_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] freed;
      logic [SIZE_W-1:0] free;
   } result_type;

endpackage

// ===== design/bump_heap_descriptor_table.sv =====
// Each item runs alone through the controller. An alloc or a query goes from
// acceptance through the response state into the result register. A free or a
// realloc first reads the descriptor table one entry per cycle through the
// single read port of the table memory until the address matches or the last
// entry has been read, and a free or a move of a block that is not the last
// one then compacts the entries above it, again one entry per cycle. The
// search and the compaction together cover the table once. A new item is
// taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
// Bump heap descriptor table
// Keeps the address and size of every live block of a bump heap and answers
// alloc, free, realloc and free space queries.
// ----------------------------------------------------------------------------
module bump_heap_descriptor_table #(
   parameter int HEAP_BYTES  = 4096,
   parameter int DESC_BYTES  = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // block_addr[11:0], req_size[24:12], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // ok
   output logic [39:0] rsp_tdata    // result_addr[11:0], freed_bytes[24:12],
                                    // free_bytes[37:25], zero fill
);

   localparam int IW = $clog2(MAX_ENTRIES);

   bhdt_pkg::request_type req;
   bhdt_pkg::result_type  res;
   bhdt_pkg::result_type  rsp_ff;
   logic                  rsp_tvalid_ff;
   logic                  res_valid;
   logic                  res_ready;
   logic                  mem_wr_en;
   logic [IW-1:0]         mem_wr_idx;
   bhdt_pkg::entry_type   mem_wr_entry;
   logic                  mem_rd_en;
   logic [IW-1:0]         mem_rd_idx;
   bhdt_pkg::entry_type   mem_rd_entry;

   assign req = '{func: bhdt_pkg::func_type'(req_tuser),
                  addr: req_tdata[11:0],
                  size: req_tdata[24:12]};

   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   bhdt_ctrl #(
      .HEAP_BYTES  (HEAP_BYTES),
      .DESC_BYTES  (DESC_BYTES),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_idx   (mem_wr_idx),
      .mem_wr_entry (mem_wr_entry),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_idx   (mem_rd_idx),
      .mem_rd_entry (mem_rd_entry)
   );

   bhdt_table #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_table (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_idx   (mem_wr_idx),
      .wr_entry (mem_wr_entry),
      .rd_en    (mem_rd_en),
      .rd_idx   (mem_rd_idx),
      .rd_entry (mem_rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {2'b00, rsp_ff.free, rsp_ff.freed, rsp_ff.addr};

endmodule

// ===== design/bhdt_table.sv =====
// ----------------------------------------------------------------------------
// Descriptor table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhdt_table #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0]    wr_idx,
   input  bhdt_pkg::entry_type               wr_entry,
   input  logic                              rd_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0]    rd_idx,
   output bhdt_pkg::entry_type               rd_entry
);

   bhdt_pkg::entry_type entry_mem [MAX_ENTRIES];
   bhdt_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== design/bhdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bump heap controller
// Holds the heap counters and walks the descriptor table to look up,
// update and compact entries.
// ----------------------------------------------------------------------------
module bhdt_ctrl #(
   parameter int HEAP_BYTES  = 4096,
   parameter int DESC_BYTES  = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bhdt_pkg::request_type            req,
   output logic                             res_valid,
   input  logic                             res_ready,
   output bhdt_pkg::result_type             res,
   output logic                             mem_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]   mem_wr_idx,
   output bhdt_pkg::entry_type              mem_wr_entry,
   output logic                             mem_rd_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]   mem_rd_idx,
   input  bhdt_pkg::entry_type              mem_rd_entry
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int HW = $clog2(HEAP_BYTES + 1);
   localparam int AW = bhdt_pkg::ADDR_W;
   localparam int SW = bhdt_pkg::SIZE_W;
   localparam int XW = ((HW > SW) ? HW : SW) + 1;

   bhdt_pkg::state_type   state_ff, state_in;
   bhdt_pkg::request_type op_ff, op_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [HW-1:0]         bump_ff, bump_in;
   logic [HW-1:0]         space_ff, space_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IW-1:0]         rd_idx_ff, rd_idx_in;
   logic [IW-1:0]         hit_idx_ff, hit_idx_in;
   logic [SW-1:0]         hit_size_ff, hit_size_in;
   logic                  hit_last_ff, hit_last_in;
   logic                  append_ff, append_in;
   logic                  res_ok_ff, res_ok_in;
   logic [AW-1:0]         res_addr_ff, res_addr_in;
   logic [SW-1:0]         res_freed_ff, res_freed_in;

   logic [XW-1:0] space_x;
   logic [XW-1:0] desc_x;
   logic [SW-1:0] size_sel;
   logic [XW-1:0] need_x;
   logic          room;
   logic          rd_match;
   logic          rd_last;
   logic [SW-1:0] grow_d;
   logic [SW-1:0] shrink_d;

   assign space_x  = XW'(space_ff);
   assign desc_x   = XW'(DESC_BYTES);
   assign size_sel = (state_ff == bhdt_pkg::ST_IDLE) ? req.size : op_ff.size;
   assign need_x   = XW'(size_sel) + desc_x;
   assign room     = (size_sel != '0) && (count_ff != CW'(MAX_ENTRIES)) && (space_x >= need_x);
   assign rd_match = rd_vld_ff && (mem_rd_entry.addr == op_ff.addr);
   assign rd_last  = ((CW'(rd_idx_ff) + CW'(1)) == count_ff);
   assign grow_d   = op_ff.size - hit_size_ff;
   assign shrink_d = hit_size_ff - op_ff.size;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bhdt_pkg::ST_IDLE;
         count_ff  <= '0;
         bump_ff   <= '0;
         space_ff  <= HW'(HEAP_BYTES);
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bump_ff   <= bump_in;
         space_ff  <= space_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_size_ff  <= hit_size_in;
      hit_last_ff  <= hit_last_in;
      append_ff    <= append_in;
      res_ok_ff    <= res_ok_in;
      res_addr_ff  <= res_addr_in;
      res_freed_ff <= res_freed_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      bump_in      = bump_ff;
      space_in     = space_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_size_in  = hit_size_ff;
      hit_last_in  = hit_last_ff;
      append_in    = append_ff;
      res_ok_in    = res_ok_ff;
      res_addr_in  = res_addr_ff;
      res_freed_in = res_freed_ff;
      mem_wr_en    = 1'b0;
      mem_wr_idx   = '0;
      mem_wr_entry = '0;
      mem_rd_en    = 1'b0;
      mem_rd_idx   = scan_ff[IW-1:0];

      unique case (state_ff)
         bhdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in        = req;
               res_ok_in    = 1'b0;
               res_addr_in  = '0;
               res_freed_in = '0;
               append_in    = 1'b0;
               scan_in      = '0;
               state_in     = bhdt_pkg::ST_RESP;
               unique case (req.func) inside
                  bhdt_pkg::FUNC_ALLOC: begin
                     if (room) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_idx   = count_ff[IW-1:0];
                        mem_wr_entry = '{addr: AW'(bump_ff), size: req.size};
                        count_in     = count_ff + CW'(1);
                        bump_in      = HW'(XW'(bump_ff) + XW'(req.size));
                        space_in     = HW'(space_x - need_x);
                        res_ok_in    = 1'b1;
                        res_addr_in  = AW'(bump_ff);
                     end
                  end
                  bhdt_pkg::FUNC_FREE, bhdt_pkg::FUNC_REALLOC: begin
                     if ((count_ff != '0) &&
                         !((req.func == bhdt_pkg::FUNC_REALLOC) && (req.size == '0))) begin
                        state_in = bhdt_pkg::ST_SEARCH;
                     end
                  end
                  bhdt_pkg::FUNC_QUERY: begin
                     res_ok_in = 1'b1;
                  end
                  default: begin
                     res_ok_in = 1'b0;
                  end
               endcase
            end
         end

         bhdt_pkg::ST_SEARCH: begin
            if (scan_ff != count_ff) begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = scan_ff[IW-1:0];
               rd_vld_in  = 1'b1;
               rd_idx_in  = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end
            if (rd_match) begin
               hit_idx_in  = rd_idx_ff;
               hit_size_in = mem_rd_entry.size;
               hit_last_in = rd_last;
               state_in    = bhdt_pkg::ST_DECIDE;
            end else if (rd_vld_ff && rd_last) begin
               state_in = bhdt_pkg::ST_RESP;
            end
         end

         bhdt_pkg::ST_DECIDE: begin
            state_in = bhdt_pkg::ST_RESP;
            if (op_ff.func == bhdt_pkg::FUNC_FREE) begin
               res_ok_in    = 1'b1;
               res_freed_in = hit_size_ff;
               space_in     = HW'(space_x + desc_x);
               if (hit_last_ff) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  scan_in  = CW'(hit_idx_ff) + CW'(1);
                  state_in = bhdt_pkg::ST_SHIFT;
               end
            end else if (op_ff.size == hit_size_ff) begin
               res_ok_in   = 1'b1;
               res_addr_in = op_ff.addr;
            end else if (op_ff.size < hit_size_ff) begin
               mem_wr_en    = 1'b1;
               mem_wr_idx   = hit_idx_ff;
               mem_wr_entry = '{addr: op_ff.addr, size: op_ff.size};
               res_ok_in    = 1'b1;
               res_addr_in  = op_ff.addr;
               if (hit_last_ff) begin
                  space_in = HW'(space_x + XW'(shrink_d));
                  bump_in  = HW'(XW'(bump_ff) - XW'(shrink_d));
               end
            end else if (hit_last_ff) begin
               if (space_x >= XW'(grow_d)) begin
                  mem_wr_en    = 1'b1;
                  mem_wr_idx   = hit_idx_ff;
                  mem_wr_entry = '{addr: op_ff.addr, size: op_ff.size};
                  space_in     = HW'(space_x - XW'(grow_d));
                  bump_in      = HW'(XW'(bump_ff) + XW'(grow_d));
                  res_ok_in    = 1'b1;
                  res_addr_in  = op_ff.addr;
               end
            end else if (room) begin
               // The block moves: it is appended at the bump pointer once the
               // table has been compacted over the old entry.
               res_ok_in   = 1'b1;
               res_addr_in = AW'(bump_ff);
               bump_in     = HW'(XW'(bump_ff) + XW'(op_ff.size));
               space_in    = HW'(space_x - XW'(op_ff.size));
               append_in   = 1'b1;
               scan_in     = CW'(hit_idx_ff) + CW'(1);
               state_in    = bhdt_pkg::ST_SHIFT;
            end
         end

         bhdt_pkg::ST_SHIFT: begin
            if (scan_ff != count_ff) begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = scan_ff[IW-1:0];
               rd_vld_in  = 1'b1;
               rd_idx_in  = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               mem_wr_en    = 1'b1;
               mem_wr_idx   = rd_idx_ff - IW'(1);
               mem_wr_entry = mem_rd_entry;
               if (rd_last) begin
                  state_in = bhdt_pkg::ST_TAIL;
               end
            end
         end

         bhdt_pkg::ST_TAIL: begin
            if (append_ff) begin
               mem_wr_en    = 1'b1;
               mem_wr_idx   = IW'(count_ff - CW'(1));
               mem_wr_entry = '{addr: res_addr_ff, size: op_ff.size};
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = bhdt_pkg::ST_RESP;
         end

         bhdt_pkg::ST_RESP: begin
            if (res_ready) begin
               state_in = bhdt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bhdt_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == bhdt_pkg::ST_IDLE);
   assign res_valid = (state_ff == bhdt_pkg::ST_RESP);
   assign res       = '{ok: res_ok_ff, addr: res_addr_ff, freed: res_freed_ff,
                        free: SW'(space_ff)};

endmodule

// ===== design/bhdt_checker.sv =====
// ----------------------------------------------------------------------------
// Bump heap descriptor table checker
// Port level checks on the request and result channels.
// ----------------------------------------------------------------------------
module bhdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [0:0]  rsp_tuser,
   input logic [39:0] rsp_tdata
);

   // A stalled result item holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // Every accepted item keeps the block busy in the cycle after the accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken again right after an accept");

   // A rejected item reports no address.
   a_reject_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[11:0] == 12'd0)
      else $error("rejected item carries an address");

   // Released bytes are reported only by a successful free.
   a_freed_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[24:12] != 13'd0) |-> rsp_tuser[0] && (rsp_tdata[11:0] == 12'd0))
      else $error("released bytes reported without a successful free");

endmodule

bind bump_heap_descriptor_table bhdt_checker u_bhdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/bump_heap_descriptor_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bump heap descriptor table testbench
// Drives alloc, free, realloc and query items into the block and checks each
// result against a behavioral copy of the heap bookkeeping kept in the bench.
// A directed pass covers the size extremes and every realloc case. Random
// traffic then works mostly on live blocks, with noise items mixed in. Both
// handshakes idle at random. One phase holds the result side off for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module bump_heap_descriptor_table_tb;

   localparam int HEAP_BYTES   = 4096;
   localparam int DESC_BYTES   = 16;
   localparam int MAX_ENTRIES  = 256;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 16;
   localparam int CYCLE_LIMIT  = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;    // func
   logic [31:0] req_tdata = '0;    // block_addr[11:0], req_size[24:12], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [0:0]  rsp_tuser;         // ok
   logic [39:0] rsp_tdata;         // result_addr[11:0], freed_bytes[24:12],
                                   // free_bytes[37:25], zero fill

   int unsigned blk_addr [MAX_ENTRIES];
   int unsigned blk_size [MAX_ENTRIES];
   int          blk_count = 0;
   int          live_bytes = 0;
   int          wasted_bytes = 0;

   bhdt_pkg::result_type pending_results [$];
   bhdt_pkg::result_type got, want;
   int          errors = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          stall_left = 0;
   int          run_left = 0;

   bump_heap_descriptor_table #(
      .HEAP_BYTES (HEAP_BYTES),
      .DESC_BYTES (DESC_BYTES),
      .MAX_ENTRIES(MAX_ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int heap_space();
      return HEAP_BYTES - blk_count * DESC_BYTES - live_bytes - wasted_bytes;
   endfunction

   function automatic int find_entry(int addr);
      for (int i = 0; i < blk_count; i++) begin
         if (blk_addr[i] == addr) return i;
      end
      return blk_count;
   endfunction

   function automatic bit bump_place(int size, output int addr);
      addr = 0;
      if (size == 0 || blk_count >= MAX_ENTRIES) return 1'b0;
      if (heap_space() - DESC_BYTES - size < 0) return 1'b0;
      addr = (live_bytes + wasted_bytes) & 'hFFF;
      blk_addr[blk_count] = addr;
      blk_size[blk_count] = size;
      blk_count++;
      live_bytes += size;
      return 1'b1;
   endfunction

   function automatic int release_entry(int idx);
      int size;
      size = blk_size[idx];
      wasted_bytes += size;
      live_bytes -= size;
      for (int i = idx; i + 1 < blk_count; i++) begin
         blk_addr[i] = blk_addr[i + 1];
         blk_size[i] = blk_size[i + 1];
      end
      blk_count--;
      return size;
   endfunction

   function automatic bhdt_pkg::result_type predict_heap_op(bhdt_pkg::func_type f,
                                                            logic [11:0] a,
                                                            logic [12:0] s);
      bhdt_pkg::result_type r;
      int idx, old, naddr, size, freed, space;
      r = '0;
      size = s;
      naddr = 0;
      case (f)
         bhdt_pkg::FUNC_ALLOC: begin
            if (bump_place(size, naddr)) begin
               r.ok = 1'b1;
               r.addr = naddr[11:0];
            end
         end
         bhdt_pkg::FUNC_FREE: begin
            idx = find_entry(a);
            if (idx < blk_count) begin
               freed = release_entry(idx);
               r.ok = 1'b1;
               r.freed = freed[12:0];
            end
         end
         bhdt_pkg::FUNC_REALLOC: begin
            idx = find_entry(a);
            if (idx < blk_count && size != 0) begin
               old = blk_size[idx];
               if (size == old) begin
                  r.ok = 1'b1;
                  r.addr = a;
               end else if (size < old) begin
                  live_bytes -= old - size;
                  if (idx + 1 != blk_count) wasted_bytes += old - size;
                  blk_size[idx] = size;
                  r.ok = 1'b1;
                  r.addr = a;
               end else if (idx + 1 == blk_count) begin
                  if (heap_space() - (size - old) >= 0) begin
                     live_bytes += size - old;
                     blk_size[idx] = size;
                     r.ok = 1'b1;
                     r.addr = a;
                  end
               end else if (bump_place(size, naddr)) begin
                  void'(release_entry(idx));
                  r.ok = 1'b1;
                  r.addr = naddr[11:0];
               end
            end
         end
         default: begin
            r.ok = 1'b1;
         end
      endcase
      space = heap_space();
      if (space < 0) space = 0;
      r.free = space[12:0];
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int small_size();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 12);
      return $urandom_range(13, 64);
   endfunction

   function automatic void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   task automatic send_item(bhdt_pkg::func_type f, logic [11:0] a, logic [12:0] s);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 2) == 0) gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {7'b0, s, a};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_heap_op(f, a, s));
   endtask

   task automatic random_heap_op();
      int r, idx, old, size;
      logic [11:0] a;
      r = $urandom_range(0, 99);
      idx = (blk_count > 0) ? $urandom_range(0, blk_count - 1) : 0;
      a = (blk_count > 0) ? blk_addr[idx][11:0] : 12'($urandom_range(0, 4095));
      old = (blk_count > 0) ? blk_size[idx] : 1;
      if (r < 35 || (r < 80 && blk_count == 0)) begin
         send_item(bhdt_pkg::FUNC_ALLOC, 12'($urandom_range(0, 4095)),
                   13'(small_size()));
      end else if (r < 60) begin
         send_item(bhdt_pkg::FUNC_FREE, a, 13'($urandom_range(0, 4096)));
      end else if (r < 80) begin
         case ($urandom_range(0, 3))
            0: size = old;
            1: size = (old > 1) ? $urandom_range(1, old - 1) : old;
            2: size = old + $urandom_range(1, 16);
            default: size = old + small_size();
         endcase
         send_item(bhdt_pkg::FUNC_REALLOC, a, 13'(size));
      end else if (r < 85) begin
         send_item(bhdt_pkg::FUNC_QUERY, 12'($urandom_range(0, 4095)),
                   13'($urandom_range(0, 4096)));
      end else if (r < 92) begin
         send_item(($urandom_range(0, 1) == 0) ? bhdt_pkg::FUNC_FREE
                                                : bhdt_pkg::FUNC_REALLOC,
                   12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096)));
      end else begin
         send_item(($urandom_range(0, 1) == 0) ? bhdt_pkg::FUNC_ALLOC
                                                : bhdt_pkg::FUNC_REALLOC,
                   a, 13'($urandom_range(0, 4096)));
      end
   endtask

   task automatic test_directed();
      send_item(bhdt_pkg::FUNC_QUERY, 12'd0, 13'd0);
      send_item(bhdt_pkg::FUNC_FREE, 12'd0, 13'd0);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd5);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd0);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'hFFF, 13'd4096);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd4081);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd4080);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd1);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd0);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd4080);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd100);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd4080);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd4081);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd10);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd20);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd30);
      send_item(bhdt_pkg::FUNC_ALLOC, 12'd0, 13'd8);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd30, 13'd10);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd0, 13'd40);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'd10, 13'd4000);
      send_item(bhdt_pkg::FUNC_FREE, 12'd30, 13'd0);
      send_item(bhdt_pkg::FUNC_FREE, 12'hFFF, 13'h1FFF);
      send_item(bhdt_pkg::FUNC_REALLOC, 12'hFFF, 13'd7);
      send_item(bhdt_pkg::FUNC_FREE, 12'd68, 13'd0);
      send_item(bhdt_pkg::FUNC_QUERY, 12'hFFF, 13'd4096);
   endtask

   task automatic test_random(int count);
      repeat (count) random_heap_op();
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_requests++;
      repeat (20) random_heap_op();
      no_idle = 1'b0;
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      repeat (40) random_heap_op();
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_idle || run_left > 0) begin
         if (run_left > 0) run_left--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         run_left = $urandom_range(0, 15);
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok = rsp_tuser[0];
         got.addr = rsp_tdata[11:0];
         got.freed = rsp_tdata[24:12];
         got.free = rsp_tdata[37:25];
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected result: ok=%0d addr=%0d freed=%0d free=%0d",
                                 got.ok, got.addr, got.freed, got.free));
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.addr !== want.addr ||
                got.freed !== want.freed || got.free !== want.free) begin
               note_error($sformatf({"mismatch: expected ok=%0d addr=%0d freed=%0d ",
                                     "free=%0d, got ok=%0d addr=%0d freed=%0d free=%0d"},
                                    want.ok, want.addr, want.freed, want.free,
                                    got.ok, got.addr, got.freed, got.free));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bump_heap_descriptor_table_tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(190);
      test_backpressure();
      test_random(100);
      test_full_rate();
      test_random(90);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("bump_heap_descriptor_table_tb: done, clean");
      end else begin
         $display("bump_heap_descriptor_table_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/bhdt_pkg.sv
design/bhdt_table.sv
design/bhdt_ctrl.sv
design/bump_heap_descriptor_table.sv
design/bhdt_checker.sv
dv/bump_heap_descriptor_table_tb.sv
